@@ rtl/core/csr_sparse_matrix_vector_multiply_unit_defines.svh @@
// Assertion macros used by the checker of the sparse matrix-vector unit.
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_DEFINES_SVH

// Check a consequence in the cycle after the antecedent holds.
`define CSR_SPMV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csr_spmv: next-cycle check failed");

// Check a consequence in the same cycle as the antecedent.
`define CSR_SPMV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csr_spmv: same-cycle check failed");

`endif

@@ rtl/core/csr_spmv_pkg.sv @@
// Shared types and constants of the sparse matrix-vector unit.
`default_nettype none

package csr_spmv_pkg;

	localparam int unsigned CMD_W       = 2;
	localparam int unsigned COL_W       = 12;
	localparam int unsigned VAL_W       = 32;
	localparam int unsigned SUM_W       = 64;
	localparam int unsigned FIRST_ROW_W = 20;
	localparam int unsigned CFG_DATA_W  = 20;
	localparam int unsigned CFG_INDEX_W = 2;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = 2;
	localparam int unsigned QUEUE_CNT_W = 3;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;

	localparam logic [COL_W-1:0] WINDOW_LOW_RESET  = '0;
	localparam logic [COL_W-1:0] WINDOW_HIGH_RESET = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_ACCUM = 2'd1,
		CMD_CLOSE = 2'd2
	} command_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FIRST_ROW   = 2'd0,
		REG_WINDOW_LOW  = 2'd1,
		REG_WINDOW_HIGH = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_ACCUM,
		OP_CLOSE
	} op_t;

	typedef struct packed {
		logic [COL_W-1:0] low;
		logic [COL_W-1:0] high;
	} window_t;

	typedef struct packed {
		op_t                      op;
		logic [COL_W-1:0]         column;
		logic signed [VAL_W-1:0]  value;
	} entry_t;

endpackage

`default_nettype wire

@@ rtl/core/csr_spmv_front.sv @@
// Front end: input handshake and classification of items into queue entries.
`default_nettype none

module csr_spmv_front import csr_spmv_pkg::*; #(
	parameter int unsigned VECTOR_DEPTH = 4096
) (
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [CMD_W-1:0]        command,
	input  logic [COL_W-1:0]        column,
	input  logic signed [VAL_W-1:0] operand_value,
	input  window_t                 window,
	input  logic                    q_full,
	output logic                    push,
	output entry_t                  entry
);

	logic in_store;
	logic in_window;
	logic keep;

	assign in_ready  = !q_full;
	assign in_store  = 32'(column) < 32'(VECTOR_DEPTH);
	assign in_window = (column >= window.low) && (column <= window.high);

	// Drop items that leave no trace: stray loads, filtered nonzeros, unused codes.
	always_comb begin
		entry.column = column;
		entry.value  = operand_value;
		entry.op     = OP_LOAD;
		keep         = 1'b0;
		case (command_t'(command))
			CMD_LOAD: begin
				entry.op = OP_LOAD;
				keep     = in_store;
			end
			CMD_ACCUM: begin
				entry.op = OP_ACCUM;
				keep     = in_store && in_window;
			end
			CMD_CLOSE: begin
				entry.op = OP_CLOSE;
				keep     = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = in_valid && in_ready && keep;

endmodule

`default_nettype wire

@@ rtl/core/csr_spmv_queue.sv @@
// Short FIFO that decouples the front end from the execution back end.
`default_nettype none

module csr_spmv_queue import csr_spmv_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output entry_t pop_entry,
	output logic   empty
);

	entry_t                 slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full      = count_q == QUEUE_CNT_W'(QUEUE_DEPTH);
	assign empty     = count_q == '0;
	assign pop_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/csr_spmv_back.sv @@
// Back end: x store access, multiply, saturating row accumulation and result register.
`default_nettype none

module csr_spmv_back import csr_spmv_pkg::*; #(
	parameter int unsigned VECTOR_DEPTH   = 4096,
	parameter int unsigned ROW_INDEX_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  entry_t                    q_entry,
	output logic                      pop,
	input  logic [FIRST_ROW_W-1:0]    first_row,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ROW_INDEX_BITS-1:0] row_index,
	output logic signed [SUM_W-1:0]   row_sum,
	output logic                      saturated
);

	localparam int unsigned AW = $clog2(VECTOR_DEPTH);
	localparam int unsigned CW = (AW > COL_W) ? AW : COL_W;
	localparam int unsigned FW = (ROW_INDEX_BITS > FIRST_ROW_W) ? ROW_INDEX_BITS : FIRST_ROW_W;

	logic signed [VAL_W-1:0] vec_mem_q [VECTOR_DEPTH];

	logic [CW-1:0]              col_wide;
	logic [AW-1:0]              addr;
	logic [FW-1:0]              first_wide;
	logic                       advance;
	logic                       close_s2;

	logic                       valid_s1;
	op_t                        op_s1;
	logic signed [VAL_W-1:0]    a_s1;
	logic signed [VAL_W-1:0]    x_s1;

	logic                       valid_s2;
	op_t                        op_s2;
	logic signed [SUM_W-1:0]    prod_s2;

	logic signed [SUM_W-1:0]    acc_q;
	logic                       clip_q;
	logic [ROW_INDEX_BITS-1:0]  rows_q;
	logic signed [SUM_W-1:0]    sum;
	logic                       ovf;
	logic signed [SUM_W-1:0]    sat_sum;

	logic                       out_valid_q;
	logic [ROW_INDEX_BITS-1:0]  row_index_q;
	logic signed [SUM_W-1:0]    row_sum_q;
	logic                       saturated_q;

	assign col_wide   = CW'(q_entry.column);
	assign addr       = col_wide[AW-1:0];
	assign first_wide = FW'(first_row);

	// Hold the whole pipe only when a close meets a full, stalled result register.
	assign close_s2 = valid_s2 && (op_s2 == OP_CLOSE);
	assign advance  = !(close_s2 && out_valid_q && !out_ready);
	assign pop      = advance && !q_empty;

	// Loads write the store; nonzeros read it. A read after a load sees the new entry.
	always_ff @(posedge clk) begin
		if (pop && (q_entry.op == OP_LOAD)) begin
			vec_mem_q[addr] <= q_entry.value;
		end
		if (advance) begin
			x_s1 <= vec_mem_q[addr];
			a_s1 <= q_entry.value;
			op_s1 <= q_entry.op;
			prod_s2 <= a_s1 * x_s1;
			op_s2 <= op_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pop && (q_entry.op != OP_LOAD);
			valid_s2 <= valid_s1;
		end
	end

	assign sum     = acc_q + prod_s2;
	assign ovf     = (acc_q[SUM_W-1] == prod_s2[SUM_W-1]) && (sum[SUM_W-1] != acc_q[SUM_W-1]);
	assign sat_sum = ovf ? (acc_q[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			clip_q <= 1'b0;
			rows_q <= '0;
		end else if (advance && valid_s2) begin
			case (op_s2)
				OP_ACCUM: begin
					acc_q  <= sat_sum;
					clip_q <= clip_q || ovf;
				end
				OP_CLOSE: begin
					acc_q  <= '0;
					clip_q <= 1'b0;
					rows_q <= rows_q + 1'b1;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && close_s2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && close_s2) begin
			row_index_q <= first_wide[ROW_INDEX_BITS-1:0] + rows_q;
			row_sum_q   <= acc_q;
			saturated_q <= clip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign row_index = row_index_q;
	assign row_sum   = row_sum_q;
	assign saturated = saturated_q;

endmodule

`default_nettype wire

@@ rtl/core/csr_sparse_matrix_vector_multiply_unit.sv @@
// A close-row item passes through the queue, the s1 and s2 stages and the result register.
// Throughput: one item per cycle unless a stalled result holds the back end;
// one 32x32 multiply and one 64-bit add per item; a four-entry queue absorbs the front end.
// Reset clears control state, the accumulator, the row count and the configuration registers.
// The x store is not cleared by reset; load each entry before a nonzero reads it.
`default_nettype none

module csr_sparse_matrix_vector_multiply_unit import csr_spmv_pkg::*; #(
	parameter int unsigned VECTOR_DEPTH   = 4096,
	parameter int unsigned ROW_INDEX_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [CMD_W-1:0]          command,
	input  logic [COL_W-1:0]          column,
	input  logic signed [VAL_W-1:0]   operand_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ROW_INDEX_BITS-1:0] row_index,
	output logic signed [SUM_W-1:0]   row_sum,
	output logic                      saturated
);

	logic [FIRST_ROW_W-1:0] first_row_q;
	window_t                window_q;

	logic   q_push;
	logic   q_pop;
	logic   q_full;
	logic   q_empty;
	entry_t q_in;
	entry_t q_out;

	// Configuration registers; the user must make writes land only while the unit is idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_row_q   <= '0;
			window_q.low  <= WINDOW_LOW_RESET;
			window_q.high <= WINDOW_HIGH_RESET;
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_FIRST_ROW:   first_row_q   <= cfg_data[FIRST_ROW_W-1:0];
				REG_WINDOW_LOW:  window_q.low  <= cfg_data[COL_W-1:0];
				REG_WINDOW_HIGH: window_q.high <= cfg_data[COL_W-1:0];
				default: begin
					first_row_q <= first_row_q;
				end
			endcase
		end
	end

	// Front end: take one transfer a cycle whenever the queue has room,
	// and drop items that cannot change any result.
	csr_spmv_front #(
		.VECTOR_DEPTH(VECTOR_DEPTH)
	) u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.column       (column),
		.operand_value(operand_value),
		.window       (window_q),
		.q_full       (q_full),
		.push         (q_push),
		.entry        (q_in)
	);

	// Decoupling queue between classification and execution.
	csr_spmv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_entry (q_out),
		.empty     (q_empty)
	);

	// Back end: store read, registered product, forwarded accumulator, result register.
	csr_spmv_back #(
		.VECTOR_DEPTH  (VECTOR_DEPTH),
		.ROW_INDEX_BITS(ROW_INDEX_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_entry   (q_out),
		.pop       (q_pop),
		.first_row (first_row_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row_index (row_index),
		.row_sum   (row_sum),
		.saturated (saturated)
	);

endmodule

`default_nettype wire

@@ rtl/core/csr_spmv_checker.sv @@
// Port-level checker of the sparse matrix-vector unit and its bind.
`default_nettype none

`include "csr_sparse_matrix_vector_multiply_unit_defines.svh"

module csr_spmv_checker import csr_spmv_pkg::*; #(
	parameter int unsigned ROW_INDEX_BITS = 20
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [ROW_INDEX_BITS-1:0] row_index,
	input logic signed [SUM_W-1:0]   row_sum,
	input logic                      saturated
);

	logic [ROW_INDEX_BITS+SUM_W:0] result_payload;

	assign result_payload = {row_index, row_sum, saturated};

	// A stalled result keeps its whole payload.
	`CSR_SPMV_ASSERT_NEXT(a_row_hold, out_valid && !out_ready, out_valid && $stable(result_payload))

	// The queue is empty right after reset, so input is taken at once.
	`CSR_SPMV_ASSERT_NOW(a_ready_after_reset, !$past(arst_n), in_ready)

	// No row can come out before the pipe has had time to fill.
	`CSR_SPMV_ASSERT_NOW(a_no_early_row, !$past(arst_n, 3), !out_valid)

endmodule

bind csr_sparse_matrix_vector_multiply_unit csr_spmv_checker #(
	.ROW_INDEX_BITS(ROW_INDEX_BITS)
) u_checker (.*);

`default_nettype wire

@@ test/tb_csr_sparse_matrix_vector_multiply_unit.sv @@
// Self-checking testbench for the CSR sparse matrix-vector multiply unit.
module tb_csr_sparse_matrix_vector_multiply_unit import csr_spmv_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned VEC_DEPTH     = 4096;
	localparam int unsigned ROW_MAX       = (1 << FIRST_ROW_W) - 1;
	localparam int unsigned COL_MAX       = VEC_DEPTH - 1;
	// Let any nonzero still in the pipe after the last row settle.
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// One finished row as the unit should report it.
	typedef struct {
		logic [FIRST_ROW_W-1:0]  row;
		logic signed [SUM_W-1:0] sum;
		logic                    sat;
	} row_result_t;

	// Drive every input to a known value from time zero.
	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    cfg_write     = 1'b0;
	logic [CFG_INDEX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0]   cfg_data      = '0;
	logic                    in_valid      = 1'b0;
	logic                    in_ready;
	logic [CMD_W-1:0]        command       = '0;
	logic [COL_W-1:0]        column        = '0;
	logic signed [VAL_W-1:0] operand_value = '0;
	logic                    out_valid;
	logic                    out_ready     = 1'b0;
	logic [FIRST_ROW_W-1:0]  row_index;
	logic signed [SUM_W-1:0] row_sum;
	logic                    saturated;

	// Idle chances in percent for the sending and the receiving side.
	int unsigned src_idle_pct  = 0;
	int unsigned sink_idle_pct = 0;
	int unsigned errors        = 0;

	// Mirror of the unit: x store, which entries were loaded, row accumulator.
	logic signed [VAL_W-1:0] x_mirror [VEC_DEPTH];
	bit                      x_loaded [VEC_DEPTH];
	logic [COL_W-1:0]        loaded_cols [$];
	logic signed [SUM_W-1:0] acc_q      = '0;
	logic                    clip_q     = 1'b0;
	logic [FIRST_ROW_W-1:0]  rows_done  = '0;
	logic [FIRST_ROW_W-1:0]  first_row_q = '0;
	logic [COL_W-1:0]        win_lo     = WINDOW_LOW_RESET;
	logic [COL_W-1:0]        win_hi     = WINDOW_HIGH_RESET;

	// Rows that have been closed but not yet reported, oldest first.
	row_result_t pending_rows [$];
	row_result_t got_row;

	csr_sparse_matrix_vector_multiply_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.column       (column),
		.operand_value(operand_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.row_index    (row_index),
		.row_sum      (row_sum),
		.saturated    (saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result channel at random; one assignment per falling edge.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// Hard stop far beyond the slowest legal run.
	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic bit in_window(input logic [COL_W-1:0] col);
		return col >= win_lo && col <= win_hi && col < VEC_DEPTH;
	endfunction

	// Advance the mirror by one accepted item; queue the row it closes, if any.
	task automatic predict_row_sums(input logic [CMD_W-1:0] cmd, input logic [COL_W-1:0] col,
			input logic signed [VAL_W-1:0] val);
		logic signed [SUM_W-1:0] prod;
		logic signed [SUM_W-1:0] total;
		row_result_t             res;
		case (cmd)
			CMD_LOAD: begin
				if (col < VEC_DEPTH) begin
					x_mirror[col] = val;
					if (!x_loaded[col]) begin
						x_loaded[col] = 1'b1;
						loaded_cols.push_back(col);
					end
				end
			end
			CMD_ACCUM: begin
				if (in_window(col)) begin
					// Exact Q16.16 x Q16.16 product, then a clipping 64-bit add.
					prod  = longint'(val) * longint'(x_mirror[col]);
					total = acc_q + prod;
					if (acc_q[SUM_W-1] == prod[SUM_W-1] && total[SUM_W-1] != acc_q[SUM_W-1]) begin
						clip_q = 1'b1;
						total  = acc_q[SUM_W-1] ? SUM_MIN : SUM_MAX;
					end
					acc_q = total;
				end
			end
			CMD_CLOSE: begin
				res.row = first_row_q + rows_done;
				res.sum = acc_q;
				res.sat = clip_q;
				pending_rows.push_back(res);
				acc_q     = '0;
				clip_q    = 1'b0;
				rows_done = rows_done + 1'b1;
			end
			default: begin
			end
		endcase
	endtask

	// Compare each result transfer with the oldest closed row.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_rows.size() == 0) begin
				$error("unexpected result: row_index %0d row_sum %0d", row_index, row_sum);
				errors++;
			end else begin
				got_row = pending_rows.pop_front();
				if (row_index !== got_row.row) begin
					$error("row_index: expected %0d, got %0d", got_row.row, row_index);
					errors++;
				end
				if (row_sum !== got_row.sum) begin
					$error("row_sum: expected %0d, got %0d", got_row.sum, row_sum);
					errors++;
				end
				if (saturated !== got_row.sat) begin
					$error("saturated: expected %0b, got %0b", got_row.sat, saturated);
					errors++;
				end
			end
		end
	end

	// Present one item at a falling edge, hold it until its transfer, then predict.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [COL_W-1:0] col,
			input logic signed [VAL_W-1:0] val);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		column        <= col;
		operand_value <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_row_sums(cmd, col, val);
	endtask

	// Drop valid, wait out every closed row, then let trailing nonzeros finish.
	task automatic drain_rows();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_FIRST_ROW:   first_row_q = data[FIRST_ROW_W-1:0];
			REG_WINDOW_LOW:  win_lo      = data[COL_W-1:0];
			REG_WINDOW_HIGH: win_hi      = data[COL_W-1:0];
			default: begin
			end
		endcase
	endtask

	// Reprogram all registers once the unit has gone quiet.
	task automatic configure(input int unsigned first, input int unsigned lo,
			input int unsigned hi);
		drain_rows();
		write_reg(REG_FIRST_ROW, CFG_DATA_W'(first));
		write_reg(REG_WINDOW_LOW, CFG_DATA_W'(lo));
		write_reg(REG_WINDOW_HIGH, CFG_DATA_W'(hi));
	endtask

	// Mix of full-range, small, extreme and near-zero Q16.16 values.
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
			7:          return 32'sh7FFF_FFFF;
			8:          return 32'sh8000_0000;
			default:    return $signed($urandom_range(0, 2)) - 1;
		endcase
	endfunction

	// Take a loaded column; half the time steer toward the window.
	function automatic logic [COL_W-1:0] pick_nonzero_col();
		logic [COL_W-1:0] col;
		col = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
		if ($urandom_range(0, 1)) begin
			for (int i = 0; i < 8 && !in_window(col); i++) begin
				col = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
			end
		end
		return col;
	endfunction

	// Registers at reset values: an empty row, then a row over both window edges.
	task automatic test_reset_defaults();
		send_item(CMD_CLOSE, '0, '0);
		send_item(CMD_LOAD, 12'd0, 32'sh8000_0000);
		send_item(CMD_LOAD, 12'd1, 32'sh0001_0000);
		send_item(CMD_LOAD, COL_W'(COL_MAX), 32'sh7FFF_FFFF);
		send_item(CMD_ACCUM, 12'd1, 32'sh0001_8000);
		send_item(CMD_ACCUM, 12'd0, 32'sh0000_0001);
		send_item(CMD_ACCUM, COL_W'(COL_MAX), 32'shFFFF_FFFF);
		send_item(CMD_CLOSE, '1, '1);
	endtask

	// Clip high, keep adding after the clip, then clip low in the next row.
	task automatic test_saturation();
		send_item(CMD_ACCUM, 12'd0, 32'sh8000_0000);
		send_item(CMD_ACCUM, 12'd0, 32'sh8000_0000);
		send_item(CMD_ACCUM, 12'd1, 32'shFFFF_0000);
		send_item(CMD_CLOSE, '0, '0);
		repeat (3) send_item(CMD_ACCUM, COL_W'(COL_MAX), 32'sh8000_0000);
		send_item(CMD_CLOSE, '0, '0);
	endtask

	// Window just inside both ends: columns 0 and the last one must not count.
	task automatic test_window();
		configure(0, 1, COL_MAX - 1);
		send_item(CMD_ACCUM, 12'd0, 32'sh7FFF_FFFF);
		send_item(CMD_ACCUM, COL_W'(COL_MAX), 32'sh7FFF_FFFF);
		send_item(CMD_ACCUM, 12'd1, 32'sh0003_0000);
		send_item(CMD_CLOSE, '0, '0);
	endtask

	// Low bound above high bound: nothing contributes.
	task automatic test_empty_window();
		configure(0, COL_MAX, 0);
		send_item(CMD_ACCUM, 12'd0, 32'sh0001_0000);
		send_item(CMD_ACCUM, COL_W'(COL_MAX), 32'sh0001_0000);
		send_item(CMD_CLOSE, '0, '0);
	endtask

	// Top row index: the reported index wraps past the counter width.
	task automatic test_row_wrap();
		configure(ROW_MAX, 0, COL_MAX);
		send_item(CMD_CLOSE, '0, '0);
		send_item(CMD_CLOSE, '0, '0);
	endtask

	// The spare command code must leave state alone and report nothing.
	task automatic test_unused_command();
		send_item(CMD_UNUSED, '1, '1);
	endtask

	// Mostly loads and well-formed rows, some long clipping rows and spare codes.
	task automatic run_random_block(input int unsigned target);
		int unsigned sent;
		int unsigned n;
		int unsigned pick;
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				n = $urandom_range(1, 16);
				repeat (n) begin
					if ($urandom_range(0, 9) < 4 && win_lo <= win_hi)
						send_item(CMD_LOAD, COL_W'($urandom_range(win_lo, win_hi)),
							pick_value());
					else
						send_item(CMD_LOAD, COL_W'($urandom_range(0, COL_MAX)), pick_value());
				end
				sent += n;
			end else if (pick < 18) begin
				send_item(CMD_UNUSED, COL_W'($urandom), $urandom);
			end else if (pick < 22) begin
				// Long row of extreme values to push the sum into the rails.
				n = $urandom_range(12, 24);
				repeat (n) begin
					send_item(CMD_ACCUM, pick_nonzero_col(),
						$urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
				end
				send_item(CMD_CLOSE, COL_W'($urandom), $urandom);
				sent += n + 1;
			end else begin
				n = $urandom_range(0, 8);
				repeat (n) begin
					if ($urandom_range(0, 19) == 0)
						send_item(CMD_UNUSED, COL_W'($urandom), $urandom);
					send_item(CMD_ACCUM, pick_nonzero_col(), pick_value());
				end
				send_item(CMD_CLOSE, COL_W'($urandom), $urandom);
				sent += n + 1;
			end
		end
	endtask

	// Three idle patterns, three register settings in each.
	task automatic test_random_traffic();
		int unsigned lo;
		int unsigned hi;
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					src_idle_pct  = 13;
					sink_idle_pct = 86;
				end
				1: begin
					src_idle_pct  = 86;
					sink_idle_pct = 13;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < 3; k++) begin
				lo = $urandom_range(0, COL_MAX);
				hi = $urandom_range(lo, COL_MAX);
				case (p * 3 + k)
					0: configure(0, 0, COL_MAX);
					1: configure($urandom_range(0, ROW_MAX), lo, hi);
					2: configure(ROW_MAX - 2, 0, COL_MAX / 2);
					3: configure($urandom_range(0, ROW_MAX), COL_MAX, COL_MAX);
					4: configure(ROW_MAX, 0, 0);
					5: begin
						lo = $urandom_range(1, COL_MAX);
						configure($urandom_range(0, ROW_MAX), lo, $urandom_range(0, lo - 1));
					end
					6: configure($urandom_range(0, ROW_MAX), lo, hi);
					7: configure(ROW_MAX - 5, 0, COL_MAX);
					default: configure(0, lo, hi);
				endcase
				run_random_block(216);
			end
		end
	endtask

	initial begin
		// Hold reset from time zero, then release it once for the whole run.
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_saturation();
		test_window();
		test_empty_window();
		test_row_wrap();
		test_unused_command();
		test_random_traffic();
		drain_rows();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
